/* rtl/core/range_bitmap_first_zero_assert.svh */
// Assertion macros for the range bitmap first-zero block.
`ifndef RANGE_BITMAP_FIRST_ZERO_ASSERT_SVH
`define RANGE_BITMAP_FIRST_ZERO_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define RBFZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RBFZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBFZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define RBFZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/rbfz_pkg.sv */
// Shared constants and controller/datapath interface types for the range bitmap block.
package rbfz_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned IO_POS_W = 10;

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVERT = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic run;
    logic publish;
  } rbfz_ctl_t;

  typedef struct packed {
    logic clear_last;
    logic done;
  } rbfz_stat_t;

endpackage

/* rtl/core/rbfz_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module rbfz_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rbfz_ctrl.sv */
// Controller state machine: clearing pass, item acceptance, word walk and result handoff.
module rbfz_ctrl
  import rbfz_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rbfz_ctl_t  ctl_o,
  input  rbfz_stat_t stat_i
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;

  always_comb begin
    ctl_o     = '0;
    state_d   = state_q;
    out_vld_d = out_vld_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl_o.run = 1'b1;
        // The finished result moves to the output register once it is free.
        if (stat_i.done && (!out_vld_q || !out_stall_i)) begin
          ctl_o.publish = 1'b1;
          out_vld_d     = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

/* rtl/core/rbfz_dp.sv */
// Datapath: bitmap memory, pipelined read-modify-write walk and first-zero capture.
module rbfz_dp
  import rbfz_pkg::*;
#(
  parameter int unsigned POSITIONS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbfz_ctl_t           ctl_i,
  output rbfz_stat_t          stat_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [IO_POS_W-1:0] range_low_i,
  input  logic [IO_POS_W-1:0] range_high_i,
  output logic [IO_POS_W-1:0] first_zero_o,
  output logic                all_ones_o
);

  localparam int unsigned WORDS      = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PW         = $clog2(POSITIONS);
  localparam int unsigned BW         = $clog2(WORDS * WORD_BITS);
  localparam int unsigned OW         = $clog2(WORD_BITS);
  localparam int unsigned XW         = ((PW > BW) ? PW : BW) + 1;
  localparam int unsigned LAST_VALID = POSITIONS - (WORDS - 1) * WORD_BITS;

  // Item registers.
  logic [CMD_W-1:0] op_q;
  logic [PW-1:0]    lo_q, hi_q;
  logic             act_q;

  // Walk position (issue stage).
  logic [AW-1:0] addr_q;
  logic [BW-1:0] base_q;
  logic          end_q;

  // Write-back stage.
  logic          s1_vld_q;
  logic [AW-1:0] s1_addr_q;
  logic [BW-1:0] s1_base_q;
  logic [OW-1:0] s1_a_q, s1_b_q;
  logic          s1_en_q;
  logic          s1_last_q;

  // First zero found so far and the published result.
  logic                found_q;
  logic [PW-1:0]       fz_q;
  logic [IO_POS_W-1:0] res_fz_q;
  logic                res_all_q;

  logic                in_act;
  logic [PW-1:0]       hi_sat;
  logic [XW-1:0]       base_x, lo_x, hi_x, top_x, d_hi, fz_sum;
  logic                in_rng, pending_upd, issue, last_word;
  logic [OW-1:0]       a_off, b_off;
  logic [WORD_BITS-1:0] rdata, upd_mask, new_word, vmask, zeros;
  logic [OW-1:0]       zero_k;
  logic                zero_hit;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  // An item changes the bitmap only with a real command, an ordered range and a low bound
  // inside the bitmap; the high bound saturates at the last position.
  always_comb begin
    in_act = ((cmd_i == CMD_SET) || (cmd_i == CMD_CLEAR) || (cmd_i == CMD_INVERT)) &&
             (range_low_i <= range_high_i) &&
             (32'(range_low_i) < 32'(POSITIONS));
    hi_sat = (32'(range_high_i) >= 32'(POSITIONS)) ? PW'(POSITIONS - 1) : PW'(range_high_i);
  end

  // Issue stage: range offsets inside the current word.
  always_comb begin
    base_x      = XW'(base_q);
    lo_x        = XW'(lo_q);
    hi_x        = XW'(hi_q);
    top_x       = base_x + XW'(WORD_BITS);
    d_hi        = hi_x - base_x;
    pending_upd = act_q && (base_x <= hi_x);
    in_rng      = pending_upd && (top_x > lo_x);
    a_off       = (lo_x > base_x) ? OW'(lo_x - base_x) : '0;
    b_off       = (d_hi >= XW'(WORD_BITS - 1)) ? OW'(WORD_BITS - 1) : OW'(d_hi);
    last_word   = (addr_q == AW'(WORDS - 1));
    // Keep walking while words remain to update or no zero has been seen yet.
    issue       = ctl_i.run && !end_q && (!found_q || pending_upd);
  end

  // Write-back stage: apply the command to the word read and look for its lowest zero.
  always_comb begin
    for (int j = 0; j < int'(WORD_BITS); j++) begin
      upd_mask[j] = s1_en_q && (OW'(j) >= s1_a_q) && (OW'(j) <= s1_b_q);
      vmask[j]    = !s1_last_q || (j < int'(LAST_VALID));
    end
    unique case (op_q)
      CMD_SET:    new_word = rdata | upd_mask;
      CMD_CLEAR:  new_word = rdata & ~upd_mask;
      CMD_INVERT: new_word = rdata ^ upd_mask;
      default:    new_word = rdata;
    endcase
    zeros  = ~new_word & vmask;
    zero_k = '0;
    for (int j = int'(WORD_BITS) - 1; j >= 0; j--) begin
      if (zeros[j]) begin
        zero_k = OW'(j);
      end
    end
    zero_hit = |zeros;
    fz_sum   = XW'(s1_base_q) + XW'(zero_k);
  end

  always_comb begin
    ram_we    = ctl_i.clear || (s1_vld_q && s1_en_q);
    ram_waddr = ctl_i.clear ? addr_q : s1_addr_q;
    ram_wdata = ctl_i.clear ? '0 : new_word;
  end

  rbfz_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      base_q   <= '0;
      end_q    <= 1'b0;
      s1_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      if (s1_vld_q && !found_q && zero_hit) begin
        found_q <= 1'b1;
      end
      if (ctl_i.load) begin
        addr_q  <= '0;
        base_q  <= '0;
        end_q   <= 1'b0;
        found_q <= 1'b0;
      end else if (ctl_i.clear) begin
        addr_q <= addr_q + AW'(1);
      end else if (issue) begin
        if (last_word) begin
          end_q <= 1'b1;
        end else begin
          addr_q <= addr_q + AW'(1);
          base_q <= base_q + BW'(WORD_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= cmd_i;
      lo_q  <= PW'(range_low_i);
      hi_q  <= hi_sat;
      act_q <= in_act;
    end
    if (issue) begin
      s1_addr_q <= addr_q;
      s1_base_q <= base_q;
      s1_a_q    <= a_off;
      s1_b_q    <= b_off;
      s1_en_q   <= in_rng;
      s1_last_q <= last_word;
    end
    if (s1_vld_q && !found_q && zero_hit) begin
      fz_q <= PW'(fz_sum);
    end
    if (ctl_i.publish) begin
      res_fz_q  <= found_q ? IO_POS_W'(fz_q) : '0;
      res_all_q <= !found_q;
    end
  end

  assign stat_o.clear_last = last_word;
  assign stat_o.done       = !issue && !s1_vld_q;
  assign first_zero_o      = res_fz_q;
  assign all_ones_o        = res_all_q;

endmodule

/* rtl/core/range_bitmap_first_zero.sv */
// Top level of the range bitmap with set, clear, invert and first-zero search.
//
// The bitmap of POSITIONS bits lives in a RAM of ceil(POSITIONS/WORD_BITS) words. After
// reset the block runs a clearing pass of one word per cycle and holds in_stall_o high
// until it ends. Each transaction is then handled by one walk over the words from word 0:
// each cycle reads a word, the next cycle writes it back with the command applied and
// checks it for a zero, so the walk moves one word per cycle through the RAM's single
// read and write ports. The walk stops once it is past the last word of the range and a
// zero has been seen, or after the last word of the bitmap. One item is in work at a
// time; the result sits in an output register, so the next transaction is taken while
// the previous result still waits on out_stall_i.
module range_bitmap_first_zero
  import rbfz_pkg::*;
#(
  parameter int unsigned POSITIONS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [IO_POS_W-1:0] range_low_i,
  input  logic [IO_POS_W-1:0] range_high_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IO_POS_W-1:0] first_zero_o,
  output logic                all_ones_o
);

`include "range_bitmap_first_zero_assert.svh"

  rbfz_ctl_t  ctl;
  rbfz_stat_t stat;

  rbfz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .stat_i      (stat)
  );

  rbfz_dp #(
    .POSITIONS (POSITIONS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cmd_i        (cmd_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .first_zero_o (first_zero_o),
    .all_ones_o   (all_ones_o)
  );

  // A taken transaction keeps the input side busy until its walk is done.
  `RBFZ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input accepted while a walk is starting")
  // A new result appears only at the end of a walk.
  `RBFZ_ASSERT_NOW(a_result_after_walk, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result raised without a walk in progress")
  // A full bitmap reports position zero.
  `RBFZ_ASSERT_NOW(a_full_reports_zero, clk_i, rst_ni, out_valid_o && all_ones_o, first_zero_o == '0, "all_ones result with nonzero position")

endmodule
